### hw/rtl/timeseries_linear_interp_wrap_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the interpolation core
// Concurrent checks clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef TIMESERIES_LINEAR_INTERP_WRAP_CORE_MACROS_SVH
`define TIMESERIES_LINEAR_INTERP_WRAP_CORE_MACROS_SVH

// same-cycle implication
`define TLI_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLI_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/tli_pkg.sv
// ---------------------------------------------------------------------------
// tli_pkg
// Types, constants and helpers of the interpolation core.
// ---------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

	localparam int DATA_W      = 32;
	localparam int FRAC_BITS   = 16;
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = 8;
	localparam int CNT_W       = 9;
	localparam int ADDR_W      = 4;
	localparam int LANES       = 3;
	localparam int LANE_W      = 2;
	localparam int VALS_W      = LANES * DATA_W;
	localparam int ENTRY_W     = VALS_W + DATA_W;
	localparam int WGT_W       = FRAC_BITS + 1;
	localparam int WIDE_W      = 36;
	localparam int WD_W        = 34;
	localparam int BASE_W      = 34;
	localparam int DELTA_W     = 35;
	localparam int PROD_W      = DELTA_W + WGT_W + 1;
	localparam int SUM_W       = PROD_W + 1;
	localparam int DIV_STEPS   = FRAC_BITS;
	localparam int MOD_STEPS   = WIDE_W;
	localparam int STEP_W      = 6;
	localparam int HALF        = 1 << (FRAC_BITS - 1);

	localparam logic [WGT_W-1:0] ONE = WGT_W'(1 << FRAC_BITS);

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_LIN  = 2'd1;
	localparam logic [1:0] MODE_WRAP = 2'd2;

	localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
	localparam logic [1:0] REG_WRAP_LOW    = 2'd1;
	localparam logic [1:0] REG_WRAP_HIGH   = 2'd2;

	typedef struct packed {
		logic        [1:0]        mode;
		logic        [IDX_W-1:0]  entry_index;
		logic signed [DATA_W-1:0] time_value;
		logic signed [DATA_W-1:0] value_x;
		logic signed [DATA_W-1:0] value_y;
		logic signed [DATA_W-1:0] value_z;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_x;
		logic signed [DATA_W-1:0] result_y;
		logic signed [DATA_W-1:0] result_z;
		logic        [IDX_W-1:0]  lower_entry;
		logic        [WGT_W-1:0]  lower_weight;
	} out_item_t;

	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tli_ram.sv
// ---------------------------------------------------------------------------
// tli_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tli_ram #(
	parameter  int WIDTH = 32,
	parameter  int DEPTH = 256,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/timeseries_linear_interp_wrap_core.sv
// ---------------------------------------------------------------------------
// timeseries_linear_interp_wrap_core
// Piecewise linear interpolation over a loaded table of Q16.16 samples.
//
// A load transfer writes one table entry. A query transfer takes the table
// through one read port: two reads for the end points, a binary search of
// up to eight probes, a 16-step shift-subtract divider for the Q0.16
// weight, two reads for the bracketing entries and one multiply plus one
// round per lane. A wrapped query passes seven values through the same
// shift-subtract unit as a 36-step modulo. The input stalls while a query
// is in flight; a finished result waits in the output register while the
// next item is taken.
// ---------------------------------------------------------------------------
`default_nettype none

`include "timeseries_linear_interp_wrap_core_macros.svh"

module timeseries_linear_interp_wrap_core import tli_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data
);

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_RD0    = 16'h0002,
		S_CHK0   = 16'h0004,
		S_CHKN   = 16'h0008,
		S_PROBE  = 16'h0010,
		S_CMP    = 16'h0020,
		S_DIV    = 16'h0040,
		S_RDLO   = 16'h0080,
		S_RDHI   = 16'h0100,
		S_GETHI  = 16'h0200,
		S_WSTART = 16'h0400,
		S_MOD    = 16'h0800,
		S_MODFIX = 16'h1000,
		S_MUL    = 16'h2000,
		S_SUM    = 16'h4000,
		S_DONE   = 16'h8000
	} state_t;

	typedef enum logic [2:0] {
		W_ZERO = 3'b001,
		W_DIFF = 3'b010,
		W_SUM  = 3'b100
	} wsel_t;

	state_t state_q, state_d;
	wsel_t  wsel_q;

	logic        [CNT_W-1:0]   ec_q;
	logic signed [DATA_W-1:0]  wlow_q;
	logic signed [DATA_W-1:0]  whigh_q;

	logic signed [DATA_W-1:0]  t_q;
	logic                      wrp_q;
	logic        [IDX_W-1:0]   n1_q;
	logic        [IDX_W-1:0]   lo_q;
	logic        [IDX_W-1:0]   hi_q;
	logic        [IDX_W-1:0]   mid_q;
	logic signed [DATA_W-1:0]  tlo_q;
	logic signed [DATA_W-1:0]  thi_q;
	logic        [WGT_W-1:0]   c_q;
	logic        [DATA_W-1:0]  rem_q;
	logic        [DATA_W-1:0]  div_q;
	logic        [WIDE_W-1:0]  sh_q;
	logic        [STEP_W-1:0]  cnt_q;
	logic                      neg_q;
	logic signed [WIDE_W-1:0]  mx_q;
	logic        [VALS_W-1:0]  va_q;
	logic        [VALS_W-1:0]  vb_q;
	logic        [VALS_W-1:0]  res_q;
	logic        [LANE_W-1:0]  lane_q;
	logic signed [DATA_W-1:0]  w0_q;
	logic signed [WD_W-1:0]    wd_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [BASE_W-1:0]  base_q;
	logic signed [WIDE_W-1:0]  rnd_q;
	logic                      out_valid_q;
	out_item_t                 out_data_q;

	logic                      in_accept;
	logic                      ram_we;
	logic        [IDX_W-1:0]   raddr;
	logic        [ENTRY_W-1:0] rdata;
	logic signed [DATA_W-1:0]  rd_time;
	logic        [VALS_W-1:0]  rd_vals;
	logic        [CNT_W-1:0]   ecm1;
	logic        [IDX_W-1:0]   n1_d;
	logic        [IDX_W:0]     msum;
	logic        [IDX_W-1:0]   mid_d;
	logic        [IDX_W-1:0]   span;
	logic                      search_more;
	logic                      tie_lo;
	logic                      clamp_lo;
	logic                      clamp_hi;
	logic                      go_left;
	logic                      step_last;
	logic                      lane_last;
	logic                      out_free;
	logic        [DATA_W:0]    num_full;
	logic        [DATA_W:0]    den_full;
	logic        [DATA_W:0]    rng_full;
	logic                      range_ok;
	logic        [DATA_W:0]    step_t;
	logic        [DATA_W+1:0]  step_sub;
	logic                      step_ge;
	logic        [DATA_W-1:0]  rem_d;
	logic        [WIDE_W-1:0]  sh_d;
	logic signed [WIDE_W-1:0]  mod_x;
	logic signed [WIDE_W:0]    r_d;
	logic        [WIDE_W:0]    negr_d;
	logic        [DATA_W-1:0]  m_d;
	logic signed [WIDE_W-1:0]  wres_d;
	logic signed [DATA_W-1:0]  a_lane;
	logic signed [DATA_W-1:0]  b_lane;
	logic signed [BASE_W-1:0]  base_d;
	logic signed [DELTA_W-1:0] delta_d;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [SUM_W-1:0]   sum_d;
	logic signed [WIDE_W-1:0]  rnd_d;
	logic                      lane_adv;
	logic signed [DATA_W-1:0]  lane_res;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q    <= CNT_W'(1);
			wlow_q  <= -32'sd205887;
			whigh_q <= 32'sd205887;
		end else if (psel && penable && pwrite) begin
			case (paddr[ADDR_W-1:2])
				REG_ENTRY_COUNT: ec_q    <= pwdata[CNT_W-1:0];
				REG_WRAP_LOW:    wlow_q  <= pwdata;
				REG_WRAP_HIGH:   whigh_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_ENTRY_COUNT: prdata = {{(32-CNT_W){1'b0}}, ec_q};
			REG_WRAP_LOW:    prdata = wlow_q;
			REG_WRAP_HIGH:   prdata = whigh_q;
			default:         prdata = '0;
		endcase
	end

	// table
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign ram_we    = in_accept && (in_data.mode == MODE_LOAD);

	always_comb begin
		case (state_q)
			S_RD0:   raddr = '0;
			S_CHK0:  raddr = n1_q;
			S_PROBE: raddr = mid_d;
			S_RDHI:  raddr = hi_q;
			default: raddr = lo_q;
		endcase
	end

	tli_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_data.entry_index),
		.wdata ({in_data.value_z, in_data.value_y, in_data.value_x, in_data.time_value}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_time = rdata[DATA_W-1:0];
	assign rd_vals = rdata[ENTRY_W-1:DATA_W];

	// search control
	assign ecm1 = ec_q - CNT_W'(1);
	assign n1_d = (ec_q == '0) ? '0 :
	              (ec_q > CNT_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1) : ecm1[IDX_W-1:0];

	assign msum        = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_d       = msum[IDX_W:1];
	assign span        = hi_q - lo_q;
	assign search_more = span > IDX_W'(1);
	assign tie_lo      = t_q == tlo_q;
	assign clamp_lo    = t_q <= rd_time;
	assign clamp_hi    = t_q >= rd_time;
	assign go_left     = t_q < rd_time;
	assign step_last   = cnt_q == STEP_W'(1);
	assign lane_last   = lane_q == LANE_W'(LANES - 1);
	assign out_free    = !out_valid_q || !out_stall;

	assign num_full = (DATA_W + 1)'(thi_q) - (DATA_W + 1)'(t_q);
	assign den_full = (DATA_W + 1)'(thi_q) - (DATA_W + 1)'(tlo_q);
	assign rng_full = (DATA_W + 1)'(whigh_q) - (DATA_W + 1)'(wlow_q);
	assign range_ok = whigh_q > wlow_q;

	// shared shift-subtract step
	assign step_t   = {rem_q, sh_q[WIDE_W-1]};
	assign step_sub = {1'b0, step_t} - {2'b00, div_q};
	assign step_ge  = !step_sub[DATA_W+1];
	assign rem_d    = step_ge ? step_sub[DATA_W-1:0] : step_t[DATA_W-1:0];
	assign sh_d     = {sh_q[WIDE_W-2:0], step_ge};

	// modulo operand and fix-up
	assign a_lane = va_q[DATA_W-1:0];
	assign b_lane = vb_q[DATA_W-1:0];

	always_comb begin
		case (wsel_q)
			W_ZERO:  mod_x = '0;
			W_DIFF:  mod_x = WIDE_W'(b_lane) - WIDE_W'(a_lane);
			default: mod_x = rnd_q;
		endcase
	end

	assign r_d    = (WIDE_W + 1)'(mod_x) - (WIDE_W + 1)'(wlow_q);
	assign negr_d = -r_d;
	assign m_d    = (neg_q && (rem_q != '0)) ? (div_q - rem_q) : rem_q;
	assign wres_d = range_ok ? (WIDE_W'($signed({1'b0, m_d})) + WIDE_W'(wlow_q)) : mx_q;

	// blend: base * one + weight * delta, rounded half up
	always_comb begin
		if (wrp_q) begin
			base_d  = BASE_W'(a_lane) + BASE_W'(wd_q);
			delta_d = DELTA_W'(w0_q) - DELTA_W'(wd_q);
		end else begin
			base_d  = BASE_W'(b_lane);
			delta_d = DELTA_W'(a_lane) - DELTA_W'(b_lane);
		end
	end

	assign prod_d = delta_d * $signed({1'b0, c_q});
	assign sum_d  = (SUM_W'(base_q) <<< FRAC_BITS) + SUM_W'(prod_q) + SUM_W'(HALF);
	assign rnd_d  = sum_d[FRAC_BITS +: WIDE_W];

	assign lane_adv = ((state_q == S_SUM) && !wrp_q) ||
	                  ((state_q == S_MODFIX) && (wsel_q == W_SUM));
	assign lane_res = (state_q == S_SUM) ? sat_data(rnd_d) : sat_data(wres_d);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_accept && (in_data.mode inside {MODE_LIN, MODE_WRAP})) begin
					state_d = S_RD0;
				end
			end
			S_RD0:    state_d = S_CHK0;
			S_CHK0:   state_d = clamp_lo ? S_RDLO : S_CHKN;
			S_CHKN:   state_d = clamp_hi ? S_RDLO : S_PROBE;
			S_PROBE:  state_d = search_more ? S_CMP : (tie_lo ? S_RDLO : S_DIV);
			S_CMP:    state_d = S_PROBE;
			S_DIV:    state_d = step_last ? S_RDLO : S_DIV;
			S_RDLO:   state_d = S_RDHI;
			S_RDHI:   state_d = S_GETHI;
			S_GETHI:  state_d = wrp_q ? S_WSTART : S_MUL;
			S_WSTART: state_d = range_ok ? S_MOD : S_MODFIX;
			S_MOD:    state_d = step_last ? S_MODFIX : S_MOD;
			S_MODFIX: begin
				case (wsel_q)
					W_ZERO:  state_d = S_WSTART;
					W_DIFF:  state_d = S_MUL;
					default: state_d = lane_last ? S_DONE : S_WSTART;
				endcase
			end
			S_MUL:    state_d = S_SUM;
			S_SUM:    state_d = wrp_q ? S_WSTART : (lane_last ? S_DONE : S_MUL);
			S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					t_q   <= in_data.time_value;
					wrp_q <= (in_data.mode == MODE_WRAP);
					n1_q  <= n1_d;
				end
			end
			S_CHK0: begin
				lo_q  <= '0;
				hi_q  <= '0;
				c_q   <= ONE;
				tlo_q <= rd_time;
			end
			S_CHKN: begin
				hi_q  <= n1_q;
				thi_q <= rd_time;
				if (clamp_hi) begin
					lo_q <= n1_q;
				end
			end
			S_PROBE: begin
				mid_q <= mid_d;
				if (!search_more) begin
					rem_q <= num_full[DATA_W-1:0];
					div_q <= den_full[DATA_W-1:0];
					sh_q  <= '0;
					cnt_q <= STEP_W'(DIV_STEPS);
				end
			end
			S_CMP: begin
				if (go_left) begin
					hi_q  <= mid_q;
					thi_q <= rd_time;
				end else begin
					lo_q  <= mid_q;
					tlo_q <= rd_time;
				end
			end
			S_DIV: begin
				rem_q <= rem_d;
				sh_q  <= sh_d;
				cnt_q <= cnt_q - STEP_W'(1);
				if (step_last) begin
					c_q <= {1'b0, sh_d[FRAC_BITS-1:0]};
				end
			end
			S_RDHI: begin
				va_q <= rd_vals;
			end
			S_GETHI: begin
				vb_q   <= rd_vals;
				lane_q <= '0;
				wsel_q <= W_ZERO;
			end
			S_WSTART: begin
				mx_q  <= mod_x;
				neg_q <= r_d[WIDE_W];
				sh_q  <= r_d[WIDE_W] ? negr_d[WIDE_W-1:0] : r_d[WIDE_W-1:0];
				rem_q <= '0;
				div_q <= rng_full[DATA_W-1:0];
				cnt_q <= STEP_W'(MOD_STEPS);
			end
			S_MOD: begin
				rem_q <= rem_d;
				sh_q  <= sh_d;
				cnt_q <= cnt_q - STEP_W'(1);
			end
			S_MODFIX: begin
				case (wsel_q)
					W_ZERO: begin
						w0_q   <= wres_d[DATA_W-1:0];
						wsel_q <= W_DIFF;
					end
					W_DIFF: begin
						wd_q <= wres_d[WD_W-1:0];
					end
					default: begin
						wsel_q <= W_DIFF;
					end
				endcase
			end
			S_MUL: begin
				prod_q <= prod_d;
				base_q <= base_d;
			end
			S_SUM: begin
				rnd_q  <= rnd_d;
				wsel_q <= W_SUM;
			end
			S_DONE: begin
				if (out_free) begin
					out_data_q.result_x     <= res_q[DATA_W-1:0];
					out_data_q.result_y     <= res_q[2*DATA_W-1:DATA_W];
					out_data_q.result_z     <= res_q[3*DATA_W-1:2*DATA_W];
					out_data_q.lower_entry  <= lo_q;
					out_data_q.lower_weight <= c_q;
				end
			end
			default: ;
		endcase

		// advance to the next lane
		if (lane_adv) begin
			res_q  <= {lane_res, res_q[VALS_W-1:DATA_W]};
			va_q   <= {{DATA_W{1'b0}}, va_q[VALS_W-1:DATA_W]};
			vb_q   <= {{DATA_W{1'b0}}, vb_q[VALS_W-1:DATA_W]};
			lane_q <= lane_q + LANE_W'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`TLI_AST_IMP(a_search_bracket, state_q == S_PROBE, (tlo_q <= t_q) && (t_q < thi_q) && (lo_q < hi_q), "search lost its bracketing pair")
	`TLI_AST_IMP(a_step_rem, (state_q == S_DIV) || (state_q == S_MOD), rem_q < div_q, "shift-subtract remainder not below divisor")
	`TLI_AST_NXT(a_result_load, (state_q == S_DONE) && out_free, out_valid_q && (out_data_q.lower_weight <= ONE), "result not presented or weight above one")

endmodule

`default_nettype wire

### tb/timeseries_linear_interp_wrap_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for timeseries_linear_interp_wrap_core
// Loads the sample table through the input stream and sets entry count and
// wrap range over APB. It then sends directed and random linear, wrapped and
// unused-mode transfers, and checks every query result against a fixed-point
// model of the table search, the division, the blend and the wrap. The
// input stream idles and the output stream stalls at random.
// ---------------------------------------------------------------------------
module timeseries_linear_interp_wrap_core_tb;
	import tli_pkg::*;

	localparam logic [1:0] MODE_IGNORED = 2'd3;
	localparam logic signed [DATA_W-1:0] W_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] W_MAX = 32'sh7FFF_FFFF;
	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam int HOLD_CYCLES = 800;
	localparam int SETTLE_CYCLES = 32;
	localparam int TAIL_CYCLES = 400;

	class interp_scoreboard;
		logic signed [DATA_W-1:0] tab_t [TABLE_DEPTH];
		logic signed [DATA_W-1:0] tab_x [TABLE_DEPTH];
		logic signed [DATA_W-1:0] tab_y [TABLE_DEPTH];
		logic signed [DATA_W-1:0] tab_z [TABLE_DEPTH];
		logic [CNT_W-1:0] entry_count;
		logic signed [DATA_W-1:0] wrap_lo;
		logic signed [DATA_W-1:0] wrap_hi;
		out_item_t expected_results[$];
		int errors;

		function new();
			entry_count = CNT_W'(1);
			wrap_lo = -32'sd205887;
			wrap_hi = 32'sd205887;
			errors = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_ENTRY_COUNT: entry_count = val[CNT_W-1:0];
				REG_WRAP_LOW: wrap_lo = val;
				REG_WRAP_HIGH: wrap_hi = val;
				default: ;
			endcase
		endfunction

		function int active_entries();
			if (entry_count == 0) return 1;
			if (entry_count > TABLE_DEPTH) return TABLE_DEPTH;
			return int'(entry_count);
		endfunction

		function longint wrap_to(longint v);
			longint span;
			longint r;
			if (wrap_hi <= wrap_lo) return v;
			span = longint'(wrap_hi) - longint'(wrap_lo);
			r = (v - longint'(wrap_lo)) % span;
			if (r < 0) r += span;
			return r + longint'(wrap_lo);
		endfunction

		function longint round_q(longint s);
			return (s + longint'(HALF)) >>> FRAC_BITS;
		endfunction

		function logic signed [DATA_W-1:0] saturate(longint v);
			if (v > longint'(W_MAX)) return W_MAX;
			if (v < longint'(W_MIN)) return W_MIN;
			return v[DATA_W-1:0];
		endfunction

		function logic signed [DATA_W-1:0] blend_lane(logic signed [DATA_W-1:0] a,
				logic signed [DATA_W-1:0] b, longint c, bit wrapped);
			longint one;
			longint s;
			one = longint'(1) << FRAC_BITS;
			if (!wrapped) return saturate(round_q(c * longint'(a) + (one - c) * longint'(b)));
			s = longint'(a) * one + c * wrap_to(0)
				+ (one - c) * wrap_to(longint'(b) - longint'(a));
			return saturate(wrap_to(round_q(s)));
		endfunction

		function out_item_t predict_query(in_item_t it);
			int n;
			int lo;
			int hi;
			int mid;
			longint t;
			longint c;
			bit wrapped;
			out_item_t r;
			wrapped = (it.mode == MODE_WRAP);
			n = active_entries();
			t = longint'(it.time_value);
			c = longint'(1) << FRAC_BITS;
			if (t <= longint'(tab_t[0])) begin
				lo = 0;
				hi = 0;
			end else if (t >= longint'(tab_t[n-1])) begin
				lo = n - 1;
				hi = n - 1;
			end else begin
				lo = 0;
				hi = n - 1;
				while (hi - lo > 1) begin
					mid = (lo + hi) >> 1;
					if (t < longint'(tab_t[mid])) hi = mid;
					else lo = mid;
				end
				c = ((longint'(tab_t[hi]) - t) << FRAC_BITS)
					/ (longint'(tab_t[hi]) - longint'(tab_t[lo]));
			end
			r.result_x = blend_lane(tab_x[lo], tab_x[hi], c, wrapped);
			r.result_y = blend_lane(tab_y[lo], tab_y[hi], c, wrapped);
			r.result_z = blend_lane(tab_z[lo], tab_z[hi], c, wrapped);
			r.lower_entry = IDX_W'(lo);
			r.lower_weight = WGT_W'(c);
			return r;
		endfunction

		function void note_transfer(in_item_t it);
			case (it.mode)
				MODE_LOAD: begin
					tab_t[it.entry_index] = it.time_value;
					tab_x[it.entry_index] = it.value_x;
					tab_y[it.entry_index] = it.value_y;
					tab_z[it.entry_index] = it.value_z;
				end
				MODE_LIN, MODE_WRAP: expected_results.push_back(predict_query(it));
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
				logic signed [63:0] got);
			if (want !== got) begin
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("result_x", want.result_x, got.result_x);
			compare_field("result_y", want.result_y, got.result_y);
			compare_field("result_z", want.result_z, got.result_z);
			compare_field("lower_entry", want.lower_entry, got.lower_entry);
			compare_field("lower_weight", want.lower_weight, got.lower_weight);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	bit steady = 1'b0;
	bit hold_request = 1'b0;
	longint cycles = 0;
	interp_scoreboard sb = new();

	timeseries_linear_interp_wrap_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	initial begin : result_stall
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (steady) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 15);
			end
		end
	end

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(15))
			0: return W_MIN;
			1: return W_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t make_item(logic [1:0] mode, logic [IDX_W-1:0] idx,
			logic [DATA_W-1:0] t, logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
			logic [DATA_W-1:0] z);
		in_item_t it;
		it.mode = mode;
		it.entry_index = idx;
		it.time_value = t;
		it.value_x = x;
		it.value_y = y;
		it.value_z = z;
		return it;
	endfunction

	function automatic in_item_t pick_item();
		in_item_t it;
		int r;
		int n;
		int k;
		longint t;
		longint tk;
		longint tn;
		longint lo_t;
		longint hi_t;
		r = $urandom_range(99);
		n = sb.active_entries();
		it = make_item(MODE_IGNORED, IDX_W'($urandom), $urandom, pick_word(), pick_word(),
			pick_word());
		if (r < 20) begin
			// keep the table ascending for most loads
			it.mode = MODE_LOAD;
			k = it.entry_index;
			lo_t = (k == 0) ? longint'(W_MIN) : longint'(sb.tab_t[k-1]) + 1;
			hi_t = (k == TABLE_DEPTH - 1) ? longint'(W_MAX) : longint'(sb.tab_t[k+1]) - 1;
			if (lo_t <= hi_t && $urandom_range(9) != 0)
				it.time_value = DATA_W'(lo_t + longint'($urandom) % (hi_t - lo_t + 1));
		end else if (r < 96) begin
			it.mode = (r < 55) ? MODE_LIN : MODE_WRAP;
			k = $urandom_range(n - 1);
			tk = longint'(sb.tab_t[k]);
			tn = (k < n - 1) ? longint'(sb.tab_t[k+1]) : tk;
			case ($urandom_range(9))
				0, 1, 2: t = tk + longint'($urandom_range(2)) - 1;
				3, 4, 5, 6: t = (tn > tk) ? tk + longint'($urandom) % (tn - tk) : tk;
				7, 8: t = longint'(it.time_value);
				default: t = $urandom_range(1) ? longint'(W_MAX) : longint'(W_MIN);
			endcase
			if (t > W_MAX) t = W_MAX;
			else if (t < W_MIN) t = W_MIN;
			it.time_value = DATA_W'(t);
		end
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		while (!steady && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_transfer(it);
		@(negedge clk);
	endtask

	task automatic wait_drained(input int settle);
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.expected_results.size() != 0);
		repeat (settle) @(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [CNT_W-1:0] count, input logic [31:0] lo,
			input logic [31:0] hi);
		wait_drained(SETTLE_CYCLES);
		apb_write(REG_ENTRY_COUNT, 32'(count));
		apb_write(REG_WRAP_LOW, lo);
		apb_write(REG_WRAP_HIGH, hi);
	endtask

	task automatic fill_table();
		longint t;
		int k;
		t = longint'(W_MIN) / 2 - longint'($urandom_range(1 << 20));
		for (k = 0; k < TABLE_DEPTH; k++) begin
			send_item(make_item(MODE_LOAD, IDX_W'(k), DATA_W'(t), pick_word(), pick_word(),
				pick_word()));
			t += ($urandom_range(3) == 0) ? $urandom_range(8, 1) : $urandom_range(1 << 23, 1);
		end
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] count, input logic [31:0] lo,
			input logic [31:0] hi, input int items, input bit calm, input bit hold,
			input bit pause);
		int i;
		set_config(count, lo, hi);
		steady = calm;
		if (hold) hold_request = 1'b1;
		for (i = 0; i < items; i++) begin
			if (pause && i == items / 2) wait_drained(0);
			send_item(pick_item());
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single entry, reset configuration
		send_item(make_item(MODE_LOAD, 0, 0, W_MAX, W_MIN, 32'sh0001_0000));
		send_item(make_item(MODE_LIN, 8'hFF, W_MIN, 0, 0, 0));
		send_item(make_item(MODE_LIN, 0, 0, '1, '1, '1));
		send_item(make_item(MODE_WRAP, 0, W_MAX, 0, 0, 0));
		send_item(make_item(MODE_IGNORED, 8'hFF, '1, '1, '1, '1));

		// two entries spanning the full time range, full wrap range
		set_config(2, W_MIN, W_MAX);
		send_item(make_item(MODE_LOAD, 0, W_MIN, W_MIN, W_MAX, 0));
		send_item(make_item(MODE_LOAD, 1, W_MAX, W_MAX, W_MIN, '1));
		send_item(make_item(MODE_LIN, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_LIN, 0, W_MIN, 0, 0, 0));
		send_item(make_item(MODE_LIN, 0, W_MAX, 0, 0, 0));
		send_item(make_item(MODE_LIN, 0, W_MIN + 1, 0, 0, 0));
		send_item(make_item(MODE_LIN, 0, W_MAX - 1, 0, 0, 0));
		send_item(make_item(MODE_WRAP, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_WRAP, 0, W_MAX - 1, 0, 0, 0));

		// empty wrap range
		set_config(2, 0, 0);
		send_item(make_item(MODE_WRAP, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_WRAP, 0, 32'sh4000_0000, 0, 0, 0));

		// zero below the wrap range
		set_config(2, 32'sh0001_0000, 32'sh0005_0000);
		send_item(make_item(MODE_WRAP, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_WRAP, 0, -5, 0, 0, 0));
		send_item(make_item(MODE_LIN, 0, -5, 0, 0, 0));

		fill_table();
		run_phase(256, -205887, 205887, 240, 1'b0, 1'b0, 1'b0);
		run_phase(0, 0, 32'sh0001_0000, 60, 1'b0, 1'b0, 1'b0);
		run_phase(511, W_MIN, W_MAX, 200, 1'b1, 1'b0, 1'b0);
		run_phase(5, -(1 << 20), 1 << 20, 200, 1'b0, 1'b1, 1'b0);
		run_phase(2, 100, -100, 120, 1'b0, 1'b0, 1'b0);
		run_phase(17, 3 << 16, 7 << 16, 200, 1'b0, 1'b0, 1'b1);
		run_phase(CNT_W'($urandom_range(511)), $urandom, $urandom, 150, 1'b0, 1'b0, 1'b0);
		run_phase(128, -205887, 205887, 120, 1'b0, 1'b0, 1'b0);

		wait_drained(TAIL_CYCLES);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tli_pkg.sv
hw/rtl/tli_ram.sv
hw/rtl/timeseries_linear_interp_wrap_core.sv
tb/timeseries_linear_interp_wrap_core_tb.sv
